FILE: rtl/stbs_pkg.sv
// Shared constants, types and helpers for the sorted table binary search block.
package stbs_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 4;
    localparam int OUT_DATA_W  = 8;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [CNT_W-1:0]          cnt_t;
    typedef logic [POS_W-1:0]          pos_t;

    typedef struct packed {
        logic   en;
        idx_t   addr;
        value_t data;
    } tbl_wr_t;

    function automatic pos_t to_pos(input idx_t idx);
        logic [IDX_W+POS_W-1:0] ext;
        begin
            ext = {{POS_W{1'b0}}, idx};
            return ext[POS_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/stbs_table.sv
// Table storage with one write port and one registered read port.
module stbs_table (
    input  logic                   aclk,
    input  stbs_pkg::tbl_wr_t      wr,
    input  stbs_pkg::idx_t         rd_addr,
    output stbs_pkg::value_t       rd_data
);

    stbs_pkg::value_t mem [stbs_pkg::TABLE_DEPTH];
    stbs_pkg::value_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/sorted_table_binary_search.sv
// Top level of the sorted table binary search block.
// Load beats (tuser low) append signed values to a table of TABLE_DEPTH entries; loads past
// a full table are dropped. A load beat with tlast set closes the set and, when the set holds
// more than one entry, runs a bubble sort through the single read port of the table. The next
// load starts a new set. A search beat (tuser high) runs a binary search with one shared
// signed comparator: at most log2(TABLE_DEPTH)+1 probes, each an issue and a compare state,
// then the result is posted from the done state, which holds while an earlier result still
// waits on the output. The input is not ready while a sort or a search is in progress.
module sorted_table_binary_search (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [stbs_pkg::VALUE_W-1:0]        s_tdata,   // value
    input  logic                                s_tuser,   // cmd
    input  logic                                s_tlast,   // last
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [stbs_pkg::OUT_DATA_W-1:0]     m_tdata    // found, position
);

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_SORT_START = 3'd1;
    localparam logic [2:0] ST_SORT_FIRST = 3'd2;
    localparam logic [2:0] ST_SORT_CMP   = 3'd3;
    localparam logic [2:0] ST_SORT_END   = 3'd4;
    localparam logic [2:0] ST_SRCH_ISSUE = 3'd5;
    localparam logic [2:0] ST_SRCH_CMP   = 3'd6;
    localparam logic [2:0] ST_SRCH_DONE  = 3'd7;

    logic [2:0]          state_reg, state_next;
    stbs_pkg::cnt_t      fill_reg, fill_next;
    logic                closed_reg, closed_next;
    stbs_pkg::cnt_t      pass_end_reg, pass_end_next;
    stbs_pkg::idx_t      k_reg, k_next;
    stbs_pkg::value_t    operand_reg, operand_next;
    stbs_pkg::cnt_t      lo_reg, lo_next;
    stbs_pkg::cnt_t      hip1_reg, hip1_next;
    stbs_pkg::idx_t      mid_reg, mid_next;
    logic                found_reg, found_next;
    stbs_pkg::pos_t      pos_reg, pos_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_found_reg, m_found_next;
    stbs_pkg::pos_t      m_pos_reg, m_pos_next;

    stbs_pkg::tbl_wr_t   tbl_wr;
    stbs_pkg::idx_t      rd_addr;
    stbs_pkg::value_t    rd_data;

    logic                in_beat;
    logic                out_free;
    logic                op_gt;
    logic                op_lt;
    stbs_pkg::cnt_t      eff_fill;
    stbs_pkg::cnt_t      new_fill;
    stbs_pkg::cnt_t      k_ext;
    logic [stbs_pkg::CNT_W:0] mid_sum;
    stbs_pkg::cnt_t      mid_full;

    stbs_table u_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // The one comparator serves both the sort and the search.
    assign op_gt = operand_reg > rd_data;
    assign op_lt = operand_reg < rd_data;

    assign eff_fill = closed_reg ? '0 : fill_reg;
    assign new_fill = (eff_fill < stbs_pkg::cnt_t'(stbs_pkg::TABLE_DEPTH)) ?
                      eff_fill + stbs_pkg::cnt_t'(1) : eff_fill;
    assign k_ext    = stbs_pkg::cnt_t'(k_reg);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hip1_reg} - (stbs_pkg::CNT_W + 1)'(1);
    assign mid_full = mid_sum[stbs_pkg::CNT_W:1];

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        closed_next   = closed_reg;
        pass_end_next = pass_end_reg;
        k_next        = k_reg;
        operand_next  = operand_reg;
        lo_next       = lo_reg;
        hip1_next     = hip1_reg;
        mid_next      = mid_reg;
        found_next    = found_reg;
        pos_next      = pos_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_found_next  = m_found_reg;
        m_pos_next    = m_pos_reg;
        tbl_wr.en     = 1'b0;
        tbl_wr.addr   = eff_fill[stbs_pkg::IDX_W-1:0];
        tbl_wr.data   = s_tdata;
        rd_addr       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    if (s_tuser == stbs_pkg::CMD_LOAD) begin
                        tbl_wr.en = (eff_fill < stbs_pkg::cnt_t'(stbs_pkg::TABLE_DEPTH));
                        fill_next = new_fill;
                        closed_next = s_tlast;
                        pass_end_next = new_fill;
                        if (s_tlast && (new_fill > stbs_pkg::cnt_t'(1))) begin
                            state_next = ST_SORT_START;
                        end
                    end else begin
                        operand_next = s_tdata;
                        lo_next      = '0;
                        hip1_next    = fill_reg;
                        state_next   = ST_SRCH_ISSUE;
                    end
                end
            end
            ST_SORT_START: begin
                rd_addr    = '0;
                state_next = ST_SORT_FIRST;
            end
            ST_SORT_FIRST: begin
                operand_next = rd_data;
                rd_addr      = stbs_pkg::idx_t'(1);
                k_next       = '0;
                state_next   = ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
                // The smaller value settles at k, the larger one moves on.
                tbl_wr.en    = 1'b1;
                tbl_wr.addr  = k_reg;
                tbl_wr.data  = op_gt ? rd_data : operand_reg;
                operand_next = op_gt ? operand_reg : rd_data;
                rd_addr      = k_reg + stbs_pkg::idx_t'(2);
                if (k_ext + stbs_pkg::cnt_t'(2) < pass_end_reg) begin
                    k_next = k_reg + stbs_pkg::idx_t'(1);
                end else begin
                    state_next = ST_SORT_END;
                end
            end
            ST_SORT_END: begin
                tbl_wr.en     = 1'b1;
                tbl_wr.addr   = stbs_pkg::idx_t'(pass_end_reg - stbs_pkg::cnt_t'(1));
                tbl_wr.data   = operand_reg;
                pass_end_next = pass_end_reg - stbs_pkg::cnt_t'(1);
                if (pass_end_reg > stbs_pkg::cnt_t'(2)) begin
                    state_next = ST_SORT_START;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SRCH_ISSUE: begin
                rd_addr  = mid_full[stbs_pkg::IDX_W-1:0];
                mid_next = mid_full[stbs_pkg::IDX_W-1:0];
                if (lo_reg < hip1_reg) begin
                    state_next = ST_SRCH_CMP;
                end else begin
                    found_next = 1'b0;
                    pos_next   = '0;
                    state_next = ST_SRCH_DONE;
                end
            end
            ST_SRCH_CMP: begin
                if (op_lt) begin
                    hip1_next  = stbs_pkg::cnt_t'(mid_reg);
                    state_next = ST_SRCH_ISSUE;
                end else if (op_gt) begin
                    lo_next    = stbs_pkg::cnt_t'(mid_reg) + stbs_pkg::cnt_t'(1);
                    state_next = ST_SRCH_ISSUE;
                end else begin
                    found_next = 1'b1;
                    pos_next   = stbs_pkg::to_pos(mid_reg);
                    state_next = ST_SRCH_DONE;
                end
            end
            ST_SRCH_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    m_pos_next   = pos_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            closed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            closed_reg  <= closed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pass_end_reg <= pass_end_next;
        k_reg        <= k_next;
        operand_reg  <= operand_next;
        lo_reg       <= lo_next;
        hip1_reg     <= hip1_next;
        mid_reg      <= mid_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
        m_found_reg  <= m_found_next;
        m_pos_reg    <= m_pos_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(stbs_pkg::OUT_DATA_W - stbs_pkg::POS_W - 1){1'b0}},
                       m_pos_reg, m_found_reg};

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= stbs_pkg::cnt_t'(stbs_pkg::TABLE_DEPTH))
        else $error("Fill count exceeds the table depth.");

    a_sort_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SORT_CMP) |-> (k_ext + stbs_pkg::cnt_t'(1) < pass_end_reg))
        else $error("Sort compare runs past the end of the pass.");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_SRCH_DONE))
        else $error("Result beat appeared without a finished search.");
`endif

endmodule
